### rtl/core/generational_handle_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit_macros
// assertion macros for the handle allocator
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_UNIT_MACROS_SVH

// condition must hold on every clock edge outside reset
`define GHA_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// trigger implies the consequence in the following cycle
`define GHA_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/gha_pkg.sv
// ----------------------------------------------------------------------------
// gha_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none
package gha_pkg;
	localparam int SLOTS     = 32;
	localparam int CMD_DEPTH = 16;
	localparam int VER_BITS  = 16;

	localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int ID_W   = 6;
	localparam int CNT_W  = $clog2(CMD_DEPTH + 1);
	localparam int CIDX_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
	localparam int FUNC_W = 3;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;

	localparam logic [FUNC_W-1:0] FN_ALLOC    = 3'd0;
	localparam logic [FUNC_W-1:0] FN_DESTROY  = 3'd1;
	localparam logic [FUNC_W-1:0] FN_VALIDATE = 3'd2;
	localparam logic [FUNC_W-1:0] FN_COMMIT   = 3'd3;
	localparam logic [FUNC_W-1:0] FN_ALL      = 3'd4;

	localparam logic [KIND_W-1:0] KIND_RESP    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CREATED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DESTROY = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
	localparam logic [STAT_W-1:0] ST_NOSLOT  = 2'd2;
	localparam logic [STAT_W-1:0] ST_QFULL   = 2'd3;

	typedef struct packed {
		logic load;
		logic op;
		logic cmt;
		logic sweep;
		logic fin;
		logic clr_idx;
	} gha_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              out_free;
		logic              cmt_done;
		logic              sweep_done;
	} gha_sts_t;
endpackage
`default_nettype wire

### rtl/core/generational_handle_allocator_unit.sv
// ----------------------------------------------------------------------------
// generational_handle_allocator_unit
// hands out slot handles with versions, queues creates and destroys, commits
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  request | in_valid in_ready func ident version      | in
//  result  | out_valid out_ready kind status out_ident | out
//          | out_version last                          |
//
//  allocate, destroy, validate and unknown codes: latch, then answer, one request at a time
//  commit: walks the queued commands in order, one table access per cycle while the result register is free
//  destroy all: commit walk, then a sweep over every opened slot, then the response
//  any step that emits waits while the result register is full and not taken
//  reset clears live marks, counters and the free list at once, no sweep
// ----------------------------------------------------------------------------
`default_nettype none
module generational_handle_allocator_unit import gha_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [ID_W-1:0]     ident,
	input  wire logic [VER_BITS-1:0] version,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [KIND_W-1:0]        kind,
	output logic [STAT_W-1:0]        status,
	output logic [ID_W-1:0]          out_ident,
	output logic [VER_BITS-1:0]      out_version,
	output logic                     last
);
	gha_cmd_t cmd;
	gha_sts_t sts;

	// sequencer
	gha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// tables, queue and result register
	gha_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.func        (func),
		.ident       (ident),
		.version     (version),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.status      (status),
		.out_ident   (out_ident),
		.out_version (out_version),
		.last        (last)
	);
endmodule
`default_nettype wire

### rtl/core/gha_ctrl.sv
// ----------------------------------------------------------------------------
// gha_ctrl
// sequencer: single-step ops, commit walk, destroy-all sweep, final response
// ----------------------------------------------------------------------------
`default_nettype none
module gha_ctrl import gha_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire gha_sts_t sts,
	output gha_cmd_t      cmd
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_CMT   = 3'd2;
	localparam logic [2:0] S_SWEEP = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q, state_d;

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.func == FN_COMMIT || sts.func == FN_ALL) begin
					cmd.clr_idx = 1'b1;
					state_d     = S_CMT;
				end else if (sts.out_free) begin
					cmd.op  = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_CMT: begin
				if (sts.cmt_done) begin
					cmd.clr_idx = 1'b1;
					state_d     = (sts.func == FN_ALL) ? S_SWEEP : S_FIN;
				end else if (sts.out_free) begin
					cmd.cmt = 1'b1;
				end
			end
			S_SWEEP: begin
				if (sts.sweep_done) begin
					state_d = S_FIN;
				end else if (sts.out_free) begin
					cmd.sweep = 1'b1;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.fin = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end
endmodule
`default_nettype wire

### rtl/core/gha_dp.sv
// ----------------------------------------------------------------------------
// gha_dp
// slot table, free list, command queue and result register
// ----------------------------------------------------------------------------
`default_nettype none
module gha_dp import gha_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gha_cmd_t            cmd,
	output gha_sts_t                 sts,
	input  wire logic [FUNC_W-1:0]   func,
	input  wire logic [ID_W-1:0]     ident,
	input  wire logic [VER_BITS-1:0] version,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic [KIND_W-1:0]        kind,
	output logic [STAT_W-1:0]        status,
	output logic [ID_W-1:0]          out_ident,
	output logic [VER_BITS-1:0]      out_version,
	output logic                     last
);
	logic [VER_BITS-1:0] ver_mem  [SLOTS];
	logic [SLOT_W-1:0]   link_mem [SLOTS];
	logic                cq_des   [CMD_DEPTH];
	logic [SLOT_W-1:0]   cq_slot  [CMD_DEPTH];
	logic [VER_BITS-1:0] cq_ver   [CMD_DEPTH];
	logic [SLOTS-1:0]    live_q;

	logic [FUNC_W-1:0]   func_q;
	logic [ID_W-1:0]     id_q;
	logic [VER_BITS-1:0] ver_q;
	logic [ID_W-1:0]     used_q;
	logic [SLOT_W-1:0]   head_q, tail_q;
	logic                empty_q;
	logic [CNT_W-1:0]    count_q;
	logic [ID_W-1:0]     idx_q;
	logic                ovalid_q;

	logic [SLOT_W-1:0]   hid, a_idx, c_slot, sw_i;
	logic [VER_BITS-1:0] a_ver;
	logic                h_ok, q_full, a_none, c_emit, c_kill, sw_live, out_free;
	logic [CIDX_W-1:0]   cidx, wcidx;

	assign out_free = !ovalid_q || out_ready;
	assign hid      = SLOT_W'(id_q - ID_W'(1));
	assign h_ok     = (id_q != '0) && (id_q <= used_q) && live_q[hid] && (ver_mem[hid] == ver_q);
	assign q_full   = (count_q == CNT_W'(CMD_DEPTH));
	assign a_none   = empty_q && (used_q == ID_W'(SLOTS));
	assign a_idx    = empty_q ? used_q[SLOT_W-1:0] : head_q;
	assign a_ver    = empty_q ? '0 : ver_mem[head_q];
	assign wcidx    = count_q[CIDX_W-1:0];
	assign cidx     = idx_q[CIDX_W-1:0];
	assign c_slot   = cq_slot[cidx];
	assign c_kill   = cq_des[cidx] && live_q[c_slot] && (ver_mem[c_slot] == cq_ver[cidx]);
	assign c_emit   = !cq_des[cidx] || c_kill;
	assign sw_i     = idx_q[SLOT_W-1:0];
	assign sw_live  = live_q[sw_i];

	assign sts.func       = func_q;
	assign sts.out_free   = out_free;
	assign sts.cmt_done   = (idx_q == ID_W'(count_q));
	assign sts.sweep_done = (idx_q == used_q);

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			id_q   <= ident;
			ver_q  <= version;
		end
	end

	// tables without reset
	always_ff @(posedge clk) begin
		if (cmd.op && func_q == FN_ALLOC && !q_full && !a_none) begin
			if (empty_q) ver_mem[a_idx] <= '0;
			cq_des[wcidx]  <= 1'b0;
			cq_slot[wcidx] <= a_idx;
			cq_ver[wcidx]  <= a_ver;
		end
		if (cmd.op && func_q == FN_DESTROY && h_ok && !q_full) begin
			cq_des[wcidx]  <= 1'b1;
			cq_slot[wcidx] <= hid;
			cq_ver[wcidx]  <= ver_mem[hid];
		end
		if (cmd.cmt && c_kill) begin
			ver_mem[c_slot] <= ver_mem[c_slot] + VER_BITS'(1);
			if (!empty_q) link_mem[tail_q] <= c_slot;
		end
		if (cmd.sweep) begin
			if (sw_live) ver_mem[sw_i] <= ver_mem[sw_i] + VER_BITS'(1);
			if (idx_q + ID_W'(1) < used_q) link_mem[sw_i] <= SLOT_W'(idx_q + ID_W'(1));
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q  <= '0;
			used_q  <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.clr_idx) idx_q <= '0;
			if (cmd.cmt || cmd.sweep) idx_q <= idx_q + ID_W'(1);
			if (cmd.op && func_q == FN_ALLOC && !q_full && !a_none) begin
				if (empty_q) begin
					live_q[a_idx] <= 1'b0;
					used_q        <= used_q + ID_W'(1);
				end
				if (empty_q || head_q == tail_q) begin
					head_q  <= '0;
					tail_q  <= '0;
					empty_q <= 1'b1;
				end else begin
					head_q <= link_mem[head_q];
				end
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.op && func_q == FN_DESTROY && h_ok && !q_full)
				count_q <= count_q + CNT_W'(1);
			if (cmd.cmt) begin
				if (!cq_des[cidx]) live_q[c_slot] <= 1'b1;
				else if (c_kill) begin
					live_q[c_slot] <= 1'b0;
					if (empty_q) begin
						head_q  <= c_slot;
						empty_q <= 1'b0;
					end
					tail_q <= c_slot;
				end
			end
			if (cmd.sweep && sw_live) live_q[sw_i] <= 1'b0;
			if (cmd.fin) begin
				count_q <= '0;
				if (func_q == FN_ALL && used_q != '0) begin
					head_q  <= '0;
					tail_q  <= SLOT_W'(used_q - ID_W'(1));
					empty_q <= 1'b0;
				end
			end
		end
	end

	// result register
	logic emit;
	assign emit = cmd.op || cmd.fin || (cmd.cmt && c_emit) || (cmd.sweep && sw_live);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        ovalid_q <= 1'b0;
		else if (emit)      ovalid_q <= 1'b1;
		else if (out_ready) ovalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			kind        <= KIND_RESP;
			status      <= ST_OK;
			out_ident   <= '0;
			out_version <= '0;
			last        <= 1'b1;
			if (cmd.op) begin
				case (func_q)
					FN_ALLOC: begin
						if (q_full) status <= ST_QFULL;
						else if (a_none) status <= ST_NOSLOT;
						else begin
							out_ident   <= ID_W'(a_idx) + ID_W'(1);
							out_version <= a_ver;
						end
					end
					FN_DESTROY: begin
						if (!h_ok) status <= ST_INVALID;
						else if (q_full) status <= ST_QFULL;
					end
					FN_VALIDATE: status <= h_ok ? ST_OK : ST_INVALID;
					default:     status <= ST_INVALID;
				endcase
			end else if (cmd.cmt) begin
				kind        <= cq_des[cidx] ? KIND_DESTROY : KIND_CREATED;
				out_ident   <= ID_W'(c_slot) + ID_W'(1);
				out_version <= ver_mem[c_slot];
				last        <= 1'b0;
			end else if (cmd.sweep) begin
				kind        <= KIND_DESTROY;
				out_ident   <= idx_q + ID_W'(1);
				out_version <= ver_mem[sw_i];
				last        <= 1'b0;
			end
		end
	end

	assign out_valid = ovalid_q;
endmodule
`default_nettype wire

### rtl/core/gha_checker.sv
// ----------------------------------------------------------------------------
// gha_checker
// port level checks on the allocator results
// ----------------------------------------------------------------------------
`default_nettype none
`include "generational_handle_allocator_unit_macros.svh"
module gha_checker import gha_pkg::*; (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire logic [KIND_W-1:0]   kind,
	input wire logic [STAT_W-1:0]   status,
	input wire logic [ID_W-1:0]     out_ident,
	input wire logic                last
);
	`GHA_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`GHA_ASSERT(a_last_resp, !out_valid || (last == (kind == KIND_RESP)), "last mismatch")
	`GHA_ASSERT(a_evt_ok, !out_valid || kind == KIND_RESP || status == ST_OK, "event with error")
	`GHA_ASSERT(a_fail_zero, !out_valid || status == ST_OK || out_ident == '0, "failed id nonzero")
endmodule

bind generational_handle_allocator_unit gha_checker u_gha_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.kind      (kind),
	.status    (status),
	.out_ident (out_ident),
	.last      (last)
);
`default_nettype wire

### bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the generational handle allocator: requests are
// predicted on acceptance, results are checked in order against the forecast
// ----------------------------------------------------------------------------
`default_nettype none
module testbench;
	import gha_pkg::*;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [ID_W-1:0]     ident;
		logic [VER_BITS-1:0] version;
	} request_t;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [STAT_W-1:0]   status;
		logic [ID_W-1:0]     ident;
		logic [VER_BITS-1:0] version;
		logic                last;
	} result_t;

	localparam int N_ITEMS   = 330;
	localparam int QUIET_AT  = 290;
	localparam int HOLD_AT   = 150;
	localparam int HOLD_LEN  = 400;
	localparam int DRAIN_CYC = 60;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [FUNC_W-1:0]   func = FN_VALIDATE;
	logic [ID_W-1:0]     ident = '0;
	logic [VER_BITS-1:0] version = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KIND_W-1:0]   kind;
	logic [STAT_W-1:0]   status;
	logic [ID_W-1:0]     out_ident;
	logic [VER_BITS-1:0] out_version;
	logic                last;

	generational_handle_allocator_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .ident(ident), .version(version),
		.out_valid(out_valid), .out_ready(out_ready),
		.kind(kind), .status(status), .out_ident(out_ident),
		.out_version(out_version), .last(last)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// shadow of the slot table, free list and command queue
	// ------------------------------------------------------------------------
	logic [VER_BITS-1:0] tbl_ver [SLOTS];
	bit                  tbl_live [SLOTS];
	bit                  tbl_mark [SLOTS];
	int                  tbl_link [SLOTS];
	int                  used_cnt;
	int                  fl_head, fl_tail;
	bit                  fl_empty;
	bit                  cq_destroy [CMD_DEPTH];
	int                  cq_slot [CMD_DEPTH];
	logic [VER_BITS-1:0] cq_ver [CMD_DEPTH];
	int                  cq_cnt;

	request_t pending_reqs[$];
	result_t  expected_results[$];

	int  n_accepted = 0;
	int  n_errors = 0;
	bit  quiet = 1'b0;

	initial begin
		used_cnt = 0;
		fl_head  = 0;
		fl_tail  = 0;
		fl_empty = 1'b1;
		cq_cnt   = 0;
		for (int i = 0; i < SLOTS; i++) begin
			tbl_ver[i]  = '0;
			tbl_live[i] = 1'b0;
			tbl_mark[i] = 1'b0;
			tbl_link[i] = 0;
		end
	end

	function automatic void post_result(logic [KIND_W-1:0] k, logic [STAT_W-1:0] s,
			int id, logic [VER_BITS-1:0] v, logic l);
		result_t r;
		r.kind    = k;
		r.status  = s;
		r.ident   = id[ID_W-1:0];
		r.version = v;
		r.last    = l;
		expected_results.insert(expected_results.size(), r);
	endfunction

	function automatic bit handle_valid(logic [ID_W-1:0] id, logic [VER_BITS-1:0] v);
		if (id == 0 || id > used_cnt || id > SLOTS)
			return 1'b0;
		if (!tbl_live[id-1])
			return 1'b0;
		return tbl_ver[id-1] == v;
	endfunction

	function automatic void free_append(int idx);
		if (fl_empty) begin
			fl_head  = idx;
			fl_tail  = idx;
			fl_empty = 1'b0;
		end else begin
			tbl_link[fl_tail] = idx;
			fl_tail = idx;
		end
	endfunction

	function automatic void retire_slot(int idx);
		post_result(KIND_DESTROY, ST_OK, idx + 1, tbl_ver[idx], 1'b0);
		tbl_live[idx] = 1'b0;
		tbl_mark[idx] = 1'b0;
		tbl_ver[idx]  = tbl_ver[idx] + 1'b1;
	endfunction

	function automatic void commit_walk();
		int s;
		for (int i = 0; i < cq_cnt; i++) begin
			s = cq_slot[i];
			if (!cq_destroy[i]) begin
				tbl_live[s] = 1'b1;
				post_result(KIND_CREATED, ST_OK, s + 1, tbl_ver[s], 1'b0);
			end else if (tbl_live[s] && tbl_ver[s] == cq_ver[i]) begin
				retire_slot(s);
				free_append(s);
			end
		end
		cq_cnt = 0;
	endfunction

	// forecast every result caused by one accepted request
	function automatic void predict_request(request_t rq);
		int idx;
		case (rq.func)
			FN_ALLOC: begin
				if (cq_cnt >= CMD_DEPTH) begin
					post_result(KIND_RESP, ST_QFULL, 0, '0, 1'b1);
				end else if (fl_empty && used_cnt >= SLOTS) begin
					post_result(KIND_RESP, ST_NOSLOT, 0, '0, 1'b1);
				end else begin
					if (fl_empty) begin
						// open a never-used slot at version zero
						idx = used_cnt;
						tbl_ver[idx]  = '0;
						tbl_live[idx] = 1'b0;
						tbl_mark[idx] = 1'b0;
						used_cnt++;
						fl_head  = idx;
						fl_tail  = idx;
						fl_empty = 1'b0;
					end
					idx = fl_head;
					if (fl_head == fl_tail) begin
						fl_head  = 0;
						fl_tail  = 0;
						fl_empty = 1'b1;
					end else begin
						fl_head = tbl_link[idx];
					end
					cq_destroy[cq_cnt] = 1'b0;
					cq_slot[cq_cnt]    = idx;
					cq_ver[cq_cnt]     = tbl_ver[idx];
					cq_cnt++;
					post_result(KIND_RESP, ST_OK, idx + 1, tbl_ver[idx], 1'b1);
				end
			end
			FN_DESTROY: begin
				if (!handle_valid(rq.ident, rq.version)) begin
					post_result(KIND_RESP, ST_INVALID, 0, '0, 1'b1);
				end else if (cq_cnt >= CMD_DEPTH) begin
					post_result(KIND_RESP, ST_QFULL, 0, '0, 1'b1);
				end else begin
					idx = rq.ident - 1;
					tbl_mark[idx] = 1'b1;
					cq_destroy[cq_cnt] = 1'b1;
					cq_slot[cq_cnt]    = idx;
					cq_ver[cq_cnt]     = tbl_ver[idx];
					cq_cnt++;
					post_result(KIND_RESP, ST_OK, 0, '0, 1'b1);
				end
			end
			FN_VALIDATE: begin
				post_result(KIND_RESP, handle_valid(rq.ident, rq.version) ? ST_OK : ST_INVALID,
					0, '0, 1'b1);
			end
			FN_COMMIT: begin
				commit_walk();
				post_result(KIND_RESP, ST_OK, 0, '0, 1'b1);
			end
			FN_ALL: begin
				commit_walk();
				if (used_cnt > 0) begin
					for (int i = 0; i < used_cnt; i++)
						if (tbl_live[i])
							retire_slot(i);
					// rechain every opened slot in index order
					for (int i = 0; i + 1 < used_cnt; i++)
						tbl_link[i] = i + 1;
					fl_head  = 0;
					fl_tail  = used_cnt - 1;
					fl_empty = 1'b0;
				end
				post_result(KIND_RESP, ST_OK, 0, '0, 1'b1);
			end
			default: post_result(KIND_RESP, ST_INVALID, 0, '0, 1'b1);
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// request driver: pops pending requests, inserts random idle bursts
	// ------------------------------------------------------------------------
	int       send_gap;
	request_t nxt;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			// forecast results at the edge where the request is taken
			if (in_valid && in_ready) begin
				predict_request(request_t'{func, ident, version});
				n_accepted <= n_accepted + 1;
			end
			if (in_valid && !in_ready) begin
				// hold the request steady until taken
			end else if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(0, 16);
			end else if (pending_reqs.size() > 0) begin
				nxt = pending_reqs.pop_front();
				in_valid <= 1'b1;
				func     <= nxt.func;
				ident    <= nxt.ident;
				version  <= nxt.version;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// result side backpressure, with one long hold to fill the block up
	// ------------------------------------------------------------------------
	int stall_left;
	bit held_once;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left <= 0;
			held_once  <= 1'b0;
		end else if (stall_left > 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!held_once && n_accepted >= HOLD_AT) begin
			out_ready  <= 1'b0;
			stall_left <= HOLD_LEN;
			held_once  <= 1'b1;
		end else if (!quiet && $urandom_range(0, 9) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 16);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// ------------------------------------------------------------------------
	// result monitor: in-order compare against the oldest forecast
	// ------------------------------------------------------------------------
	result_t got, want;

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			got = '{kind, status, out_ident, out_version, last};
			if (expected_results.size() == 0) begin
				$display("%0t unexpected result: kind %0d status %0d ident %0d version %0d last %0d",
					$time, kind, status, out_ident, out_version, last);
				n_errors++;
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					$display("%0t mismatch: expected kind %0d status %0d ident %0d version %0d last %0d",
						$time, want.kind, want.status, want.ident, want.version, want.last);
					$display("%0t           actual   kind %0d status %0d ident %0d version %0d last %0d",
						$time, got.kind, got.status, got.ident, got.version, got.last);
					n_errors++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	function automatic request_t mk(logic [FUNC_W-1:0] f, int id, int v);
		request_t r;
		r.func    = f;
		r.ident   = id[ID_W-1:0];
		r.version = v[VER_BITS-1:0];
		return r;
	endfunction

	function automatic void add_req(request_t r);
		pending_reqs.insert(pending_reqs.size(), r);
	endfunction

	// random request, mostly well-formed handles taken from the shadow table
	function automatic request_t random_request(bit alloc_heavy);
		int r, id, v;
		logic [FUNC_W-1:0] f;
		r = $urandom_range(0, 99);
		if (alloc_heavy)
			f = (r < 60) ? FN_ALLOC : (r < 75) ? FN_DESTROY : (r < 88) ? FN_VALIDATE :
				(r < 97) ? FN_COMMIT : (r < 98) ? FN_ALL : FUNC_W'($urandom_range(5, 7));
		else
			f = (r < 30) ? FN_ALLOC : (r < 55) ? FN_DESTROY : (r < 75) ? FN_VALIDATE :
				(r < 93) ? FN_COMMIT : (r < 97) ? FN_ALL : FUNC_W'($urandom_range(5, 7));
		if (used_cnt > 0 && $urandom_range(0, 99) < 85) begin
			id = $urandom_range(1, used_cnt);
			v  = tbl_ver[id-1];
			if ($urandom_range(0, 9) == 0)
				v = v ^ (1 << $urandom_range(0, VER_BITS - 1));
		end else begin
			id = $urandom_range(0, 63);
			v  = $urandom_range(0, 65535);
		end
		return mk(f, id, v);
	endfunction

	int gen_count;

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed part
		add_req(mk(FN_ALL, 0, 0));          // destroy-all on an empty table
		add_req(mk(FN_ALLOC, 0, 0));
		add_req(mk(FN_ALLOC, 0, 0));
		add_req(mk(FN_VALIDATE, 1, 0));     // created but not yet committed
		add_req(mk(FN_DESTROY, 1, 0));      // not active, invalid
		add_req(mk(FN_COMMIT, 0, 0));
		add_req(mk(FN_VALIDATE, 1, 0));
		add_req(mk(FN_VALIDATE, 1, 16'hffff));
		add_req(mk(FN_VALIDATE, 0, 0));     // ident zero
		add_req(mk(FN_VALIDATE, 63, 16'hffff));
		add_req(mk(FN_VALIDATE, 3, 0));     // above opened slots
		add_req(mk(FN_DESTROY, 2, 0));
		add_req(mk(FN_DESTROY, 2, 0));      // double destroy, skipped on commit
		add_req(mk(FN_COMMIT, 0, 0));
		add_req(mk(FN_ALLOC, 0, 0));        // reuses freed slot, bumped version
		add_req(mk(FUNC_W'(5), 42, 16'h5555));   // unknown codes
		add_req(mk(FUNC_W'(6), 21, 16'haaaa));
		add_req(mk(FUNC_W'(7), 63, 16'hffff));
		add_req(mk(FN_DESTROY, 1, 0));
		add_req(mk(FN_ALL, 0, 0));          // commits, then frees the rest
		add_req(mk(FN_ALLOC, 0, 0));
		gen_count = pending_reqs.size();

		// random part, alternating allocate-heavy and balanced phases
		while (gen_count < N_ITEMS) begin
			@(negedge clk);
			if (n_accepted >= QUIET_AT)
				quiet = 1'b1;
			if (pending_reqs.size() < 1 && !in_valid) begin
				add_req(random_request(((gen_count / 40) % 2) == 0));
				gen_count++;
			end
		end

		// drain
		quiet = 1'b1;
		while (pending_reqs.size() > 0 || in_valid || expected_results.size() > 0)
			@(negedge clk);
		repeat (DRAIN_CYC) @(negedge clk);

		if (n_errors == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

	// run limit
	initial begin
		#6000000;
		$display("CHECK FAILED");
		$finish;
	end
endmodule
`default_nettype wire

### sim.f
+incdir+rtl/core
rtl/core/gha_pkg.sv
rtl/core/gha_ctrl.sv
rtl/core/gha_dp.sv
rtl/core/generational_handle_allocator_unit.sv
rtl/core/gha_checker.sv
bench/testbench.sv
